[sv/ybad_pkg.sv]
// shared types and constants for the yuyv block-average downscaler
// no dependencies; imported by every module of the block but ybad_ram
package ybad_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_SCALE = 16;

   localparam int PIX_W   = 8;
   localparam int SUM_W   = 16;
   localparam int DIM_W   = 11;
   localparam int SCALE_W = 5;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int PHASE_W = $clog2(MAX_SCALE);
   localparam int CNT_W   = 2 * PHASE_W + 1;
   localparam int REM_W   = CNT_W - 1;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W  = $clog2(DIV_STEPS);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = DIM_W'(480);
   localparam logic [SCALE_W-1:0] RST_SCALE      = SCALE_W'(2);
   localparam logic [DIM_W-1:0]   RST_DST_WIDTH  = DIM_W'(320);
   localparam logic [DIM_W-1:0]   RST_DST_HEIGHT = DIM_W'(240);

   typedef enum logic [2:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_SCALE      = 3'd2,
      CSR_DST_WIDTH  = 3'd3,
      CSR_DST_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_UPDATE = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_EMIT   = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

   // geometry after clamping
   typedef struct packed {
      logic [DIM_W-1:0]   src_width;
      logic [DIM_W-1:0]   src_height;
      logic [SCALE_W-1:0] scale;
      logic [DIM_W-1:0]   dst_width;
      logic [DIM_W-1:0]   dst_height;
   } geom_type;

endpackage

[sv/ybad_ram.sv]
// generic single-port-write, registered-read ram
// no dependencies
module ybad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ybad_divider.sv]
// restoring divider lane, one quotient bit per step
// depends on ybad_pkg
module ybad_divider
   import ybad_pkg::*;
(
   input  logic               clock,
   input  logic               load,
   input  logic               step,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [CNT_W-1:0]   divisor,
   output logic [PIX_W-1:0]   quotient
);

   logic [SUM_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff;
   logic [CNT_W-1:0] trial;
   logic             ge;

   always_comb begin
      trial    = {rem_ff, shift_ff[SUM_W-1]};
      ge       = (trial >= div_ff);
      rem_in   = ge ? REM_W'(trial - div_ff) : REM_W'(trial);
      shift_in = {shift_ff[SUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= dividend;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (step) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
   end

   // a block mean never exceeds a byte
   assign quotient = shift_ff[PIX_W-1:0];

endmodule

[sv/ybad_datapath.sv]
// datapath: positions, line accumulators, divider lanes and result register
// depends on ybad_pkg, ybad_ram, ybad_divider
module ybad_datapath
   import ybad_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  geom_type         geom,
   input  logic             restart,
   input  logic [PIX_W-1:0] in_luma,
   input  logic [PIX_W-1:0] in_cb,
   input  logic [PIX_W-1:0] in_cr,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [PIX_W-1:0] out_luma,
   output logic [PIX_W-1:0] out_cb,
   output logic [PIX_W-1:0] out_cr,
   output logic             out_kept,
   output logic             out_end
);

   logic [PIX_W-1:0]   y_ff, u_ff, v_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [PHASE_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [COL_W-1:0]   ocol_ff, ocol_in;
   logic [DIM_W-1:0]   orow_ff, orow_in;
   logic               kept_ff, end_ff;
   logic               valid_ff;
   logic [PIX_W-1:0]   luma_ff, cb_ff, cr_ff;
   logic               okept_ff, oend_ff;

   logic [3*SUM_W-1:0] rd_data, wr_data;
   logic [SUM_W-1:0]   old_l, old_c, old_r, new_l, new_c, new_r;
   logic               first, even, last_col, last_row, col_wrap, row_wrap;
   logic [SCALE_W-1:0] bx_next, by_next;
   logic [CNT_W-1:0]   cnt, ccnt;
   logic [PIX_W-1:0]   q_l, q_c, q_r;

   ybad_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_WIDTH)) u_sums (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(ocol_ff),
      .wr_data(wr_data),
      .rd_en  (cmd.capture),
      .rd_addr(ocol_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      {old_l, old_c, old_r} = rd_data;
      first    = (bx_ff == '0) && (by_ff == '0);
      even     = !bx_ff[0];
      new_l    = first ? SUM_W'(y_ff) : SUM_W'(old_l + SUM_W'(y_ff));
      new_c    = first ? SUM_W'(u_ff) : (even ? SUM_W'(old_c + SUM_W'(u_ff)) : old_c);
      new_r    = first ? SUM_W'(v_ff) : (even ? SUM_W'(old_r + SUM_W'(v_ff)) : old_r);
      wr_data  = {new_l, new_c, new_r};

      bx_next  = SCALE_W'(bx_ff) + SCALE_W'(1);
      by_next  = SCALE_W'(by_ff) + SCALE_W'(1);
      col_wrap = (DIM_W'(col_ff) + DIM_W'(1)) >= geom.src_width;
      row_wrap = (row_ff + DIM_W'(1)) >= geom.src_height;
      last_col = (bx_next == geom.scale) || col_wrap;
      last_row = (by_next == geom.scale) || row_wrap;
      status.emit = last_col && last_row && (DIM_W'(ocol_ff) < geom.dst_width)
                    && (orow_ff < geom.dst_height);
      status.out_free = !valid_ff || !out_stall;

      // pixel and chroma-sample counts of the clipped block
      cnt  = CNT_W'(bx_next) * CNT_W'(by_next);
      ccnt = CNT_W'(bx_next[SCALE_W-1:1] + (SCALE_W-1)'(bx_next[0])) * CNT_W'(by_next);

      col_in  = col_ff;
      row_in  = row_ff;
      bx_in   = bx_ff;
      by_in   = by_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (col_wrap) begin
         col_in  = '0;
         bx_in   = '0;
         ocol_in = '0;
         if (row_wrap) begin
            row_in  = '0;
            by_in   = '0;
            orow_in = '0;
         end else begin
            row_in = row_ff + DIM_W'(1);
            if (by_next >= geom.scale) begin
               by_in   = '0;
               orow_in = orow_ff + DIM_W'(1);
            end else begin
               by_in = PHASE_W'(by_next);
            end
         end
      end else begin
         col_in = col_ff + COL_W'(1);
         if (bx_next >= geom.scale) begin
            bx_in   = '0;
            ocol_in = ocol_ff + COL_W'(1);
         end else begin
            bx_in = PHASE_W'(bx_next);
         end
      end
   end

   ybad_divider u_div_luma (
      .clock(clock), .load(cmd.update), .step(cmd.div_step),
      .dividend(new_l), .divisor(cnt), .quotient(q_l)
   );
   ybad_divider u_div_cb (
      .clock(clock), .load(cmd.update), .step(cmd.div_step),
      .dividend(new_c), .divisor(ccnt), .quotient(q_c)
   );
   ybad_divider u_div_cr (
      .clock(clock), .load(cmd.update), .step(cmd.div_step),
      .dividend(new_r), .divisor(ccnt), .quotient(q_r)
   );

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bx_ff   <= '0;
         by_ff   <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else if (cmd.update) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (!out_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         y_ff <= in_luma;
         u_ff <= in_cb;
         v_ff <= in_cr;
      end
      if (cmd.update) begin
         kept_ff <= !ocol_ff[0];
         end_ff  <= (DIM_W'(ocol_ff) + DIM_W'(1) == geom.dst_width)
                    && (orow_ff + DIM_W'(1) == geom.dst_height);
      end
      if (cmd.out_load) begin
         luma_ff  <= q_l;
         cb_ff    <= q_c;
         cr_ff    <= q_r;
         okept_ff <= kept_ff;
         oend_ff  <= end_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_luma  = luma_ff;
   assign out_cb    = cb_ff;
   assign out_cr    = cr_ff;
   assign out_kept  = okept_ff;
   assign out_end   = oend_ff;

endmodule

[sv/ybad_ctrl.sv]
// controller: sequences capture, update, divide and result hand-off
// depends on ybad_pkg
module ybad_ctrl
   import ybad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      in_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            in_stall    = 1'b0;
            cmd.capture = in_valid;
            if (in_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            step_in    = '0;
            state_in   = status.emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/yuyv_block_average_downscaler.sv]
// yuyv block-average downscaler: one source pixel per beat, one result per finished block inside the destination
// a pixel with no result is captured, then its line sum is updated; a pixel closing a block
// inside the destination also runs the divide steps and then the result hand-off
// no new pixel is accepted until the last one is done with; the hand-off also waits while rsp stalls
// synchronous active-high reset: geometry to 640x480 scale 2 into 320x240, positions to zero
// the line sums need no clearing: a block's first pixel overwrites its entry
module yuyv_block_average_downscaler
   import ybad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pixel_luma,
   input  logic [PIX_W-1:0]      req_pair_cb,
   input  logic [PIX_W-1:0]      req_pair_cr,
   // block result
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_avg_luma,
   output logic [PIX_W-1:0]      rsp_avg_cb,
   output logic [PIX_W-1:0]      rsp_avg_cr,
   output logic                  rsp_chroma_kept,
   output logic                  rsp_frame_end,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [DIM_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [SCALE_W-1:0] scale_ff;
   csr_index_type      csr_idx;
   logic               csr_wr, restart;
   geom_type           geom;
   cmd_type            cmd;
   status_type         status;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   // register file; any write to a known register restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         scale_ff      <= RST_SCALE;
         dst_width_ff  <= RST_DST_WIDTH;
         dst_height_ff <= RST_DST_HEIGHT;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_SRC_WIDTH:  src_width_ff  <= pwdata[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= pwdata[DIM_W-1:0];
            CSR_SCALE:      scale_ff      <= pwdata[SCALE_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= pwdata[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = 1'b0;
      prdata  = '0;
      case (csr_idx)
         CSR_SRC_WIDTH: begin
            restart = csr_wr;
            prdata  = CSR_DATA_W'(src_width_ff);
         end
         CSR_SRC_HEIGHT: begin
            restart = csr_wr;
            prdata  = CSR_DATA_W'(src_height_ff);
         end
         CSR_SCALE: begin
            restart = csr_wr;
            prdata  = CSR_DATA_W'(scale_ff);
         end
         CSR_DST_WIDTH: begin
            restart = csr_wr;
            prdata  = CSR_DATA_W'(dst_width_ff);
         end
         CSR_DST_HEIGHT: begin
            restart = csr_wr;
            prdata  = CSR_DATA_W'(dst_height_ff);
         end
         default: ;
      endcase
   end

   // clamp geometry: zero source sizes and scale become one, source width and scale capped at their maxima
   always_comb begin
      if (src_width_ff == '0) begin
         geom.src_width = DIM_W'(1);
      end else if (src_width_ff > DIM_W'(MAX_WIDTH)) begin
         geom.src_width = DIM_W'(MAX_WIDTH);
      end else begin
         geom.src_width = src_width_ff;
      end
      geom.src_height = (src_height_ff == '0) ? DIM_W'(1) : src_height_ff;
      if (scale_ff == '0) begin
         geom.scale = SCALE_W'(1);
      end else if (scale_ff > SCALE_W'(MAX_SCALE)) begin
         geom.scale = SCALE_W'(MAX_SCALE);
      end else begin
         geom.scale = scale_ff;
      end
      geom.dst_width  = dst_width_ff;
      geom.dst_height = dst_height_ff;
   end

   ybad_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_valid),
      .in_stall(req_stall),
      .status  (status),
      .cmd     (cmd)
   );

   ybad_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .geom     (geom),
      .restart  (restart),
      .in_luma  (req_pixel_luma),
      .in_cb    (req_pair_cb),
      .in_cr    (req_pair_cr),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_luma (rsp_avg_luma),
      .out_cb   (rsp_avg_cb),
      .out_cr   (rsp_avg_cr),
      .out_kept (rsp_chroma_kept),
      .out_end  (rsp_frame_end)
   );

   // an accepted beat is always followed by a busy cycle for the accumulator update
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepted beat");

   // a fresh result only comes out of the hand-off state, where input is stalled
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while input side was idle");

   // the sums ram is only read on an accepted beat
   a_read_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_valid && !req_stall))
      else $error("sums read without an accepted beat");

endmodule

[verif/tb.sv]
// self-checking testbench for yuyv_block_average_downscaler
// depends on ybad_pkg and the block's rtl; predicts block averages from the pixel stream
class block_average_board;
   typedef struct {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       kept;
      logic       fend;
   } avg_beat_type;

   int unsigned src_w, src_h, scale, dst_w, dst_h;
   logic [15:0] luma_acc [1024];
   logic [15:0] cb_acc [1024];
   logic [15:0] cr_acc [1024];
   int unsigned col, row, bx, by, ocol, orow;
   avg_beat_type pending[$];
   int errors;

   function new();
      src_w = 640; src_h = 480; scale = 2; dst_w = 320; dst_h = 240;
      foreach (luma_acc[i]) begin
         luma_acc[i] = 0; cb_acc[i] = 0; cr_acc[i] = 0;
      end
      errors = 0;
      restart();
   endfunction

   function void restart();
      col = 0; row = 0; bx = 0; by = 0; ocol = 0; orow = 0;
   endfunction

   function void write_reg(int idx, logic [31:0] val);
      case (idx)
         0: src_w = val[10:0];
         1: src_h = val[10:0];
         2: scale = val[4:0];
         3: dst_w = val[10:0];
         4: dst_h = val[10:0];
         default: return;
      endcase
      restart();
   endfunction

   // note one accepted pixel, queue the block average it closes, if any
   function void note_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
      int unsigned sw, sh, sc, cnt, ccnt;
      bit last_c, last_r;
      avg_beat_type b;
      sw = (src_w < 1) ? 1 : (src_w > 1024 ? 1024 : src_w);
      sh = (src_h < 1) ? 1 : src_h;
      sc = (scale < 1) ? 1 : (scale > 16 ? 16 : scale);
      if (ocol < 1024) begin
         if (bx == 0 && by == 0) begin
            luma_acc[ocol] = y; cb_acc[ocol] = u; cr_acc[ocol] = v;
         end else begin
            luma_acc[ocol] = luma_acc[ocol] + y;
            if (bx % 2 == 0) begin
               cb_acc[ocol] = cb_acc[ocol] + u;
               cr_acc[ocol] = cr_acc[ocol] + v;
            end
         end
         last_c = (bx + 1 == sc) || (col + 1 >= sw);
         last_r = (by + 1 == sc) || (row + 1 >= sh);
         if (last_c && last_r && ocol < dst_w && orow < dst_h) begin
            cnt = (bx + 1) * (by + 1);
            ccnt = ((bx + 2) / 2) * (by + 1);
            b.luma = 8'(luma_acc[ocol] / cnt);
            b.cb = 8'(cb_acc[ocol] / ccnt);
            b.cr = 8'(cr_acc[ocol] / ccnt);
            b.kept = (ocol % 2 == 0);
            b.fend = (ocol + 1 == dst_w && orow + 1 == dst_h);
            pending.push_back(b);
         end
      end
      if (col + 1 >= sw) begin
         col = 0; bx = 0; ocol = 0;
         if (row + 1 >= sh) begin
            row = 0; by = 0; orow = 0;
         end else begin
            row++; by++;
            if (by >= sc) begin
               by = 0; orow++;
            end
         end
      end else begin
         col++; bx++;
         if (bx >= sc) begin
            bx = 0; ocol++;
         end
      end
   endfunction

   function void check_beat(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic k, logic f);
      avg_beat_type b;
      if (pending.size() == 0) begin
         $error("unexpected result beat");
         errors++;
         return;
      end
      b = pending.pop_front();
      if (y !== b.luma) begin
         $error("avg_luma exp %0d got %0d", b.luma, y); errors++;
      end
      if (u !== b.cb) begin
         $error("avg_cb exp %0d got %0d", b.cb, u); errors++;
      end
      if (v !== b.cr) begin
         $error("avg_cr exp %0d got %0d", b.cr, v); errors++;
      end
      if (k !== b.kept) begin
         $error("chroma_kept exp %0d got %0d", b.kept, k); errors++;
      end
      if (f !== b.fend) begin
         $error("frame_end exp %0d got %0d", b.fend, f); errors++;
      end
   endfunction
endclass

module tb;
   import ybad_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_pixel_luma = 0, req_pair_cb = 0, req_pair_cr = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_avg_luma, rsp_avg_cb, rsp_avg_cr;
   logic rsp_chroma_kept, rsp_frame_end;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = 0;
   logic [CSR_DATA_W-1:0] pwdata = 0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   block_average_board board = new();

   // receiver behavior: random stalls, or a long hold-off when requested
   bit hold_off = 0;
   bit quiet_rx = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   yuyv_block_average_downscaler DUT (.*);

   // result side: check each accepted beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_beat(rsp_avg_luma, rsp_avg_cb, rsp_avg_cr, rsp_chroma_kept,
                          rsp_frame_end);
   end

   // stall process: per beat draw a random wait, none when quiet_rx is set, long hold-off on demand
   initial begin : rx_stall_proc
      int w;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         w = quiet_rx ? 0 : $urandom_range(0, 9);
         rsp_stall <= (w != 0);
         repeat (w) @(posedge clock);
         rsp_stall <= 0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && !hold_off) @(posedge clock);
      end
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_ADDR_W'(4 * int'(idx)); pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.write_reg(int'(idx), val);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   // push one pixel beat, with a random gap before it unless gaps is clear
   task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 9) : 0;
      if (w != 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1; req_pixel_luma <= y; req_pair_cb <= u; req_pair_cr <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(y, u, v);
   endtask

   // wait for all results, plus the divide latency for blocks still in flight
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(int sw, int sh, int sc, int dw, int dh);
      drain();
      csr_write(CSR_SRC_WIDTH, sw);
      csr_write(CSR_SRC_HEIGHT, sh);
      csr_write(CSR_SCALE, sc);
      csr_write(CSR_DST_WIDTH, dw);
      csr_write(CSR_DST_HEIGHT, dh);
   endtask

   task automatic random_frames(int n, bit gaps);
      for (int i = 0; i < n; i++)
         send_pixel($urandom, $urandom, $urandom, gaps);
   endtask

   initial begin : stimulus
      int sw, sh, sc;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes of pixel values on a small 4x4 frame, scale 2
      setup(4, 4, 2, 2, 2);
      send_pixel(8'hff, 8'hff, 8'hff, 0);
      send_pixel(8'hff, 8'hff, 8'hff, 0);
      send_pixel(8'h00, 8'h00, 8'h00, 0);
      send_pixel(8'h00, 8'h00, 8'h00, 0);
      send_pixel(8'hff, 8'hff, 8'hff, 0);
      send_pixel(8'hff, 8'hff, 8'hff, 0);
      send_pixel(8'h01, 8'h80, 8'h7f, 0);
      send_pixel(8'hfe, 8'h7f, 8'h80, 0);
      // scale one and oversized scale (clamped), zero geometry
      setup(3, 1, 1, 3, 1);
      random_frames(3, 0);
      setup(5, 3, 31, 1, 1);
      random_frames(5, 0);
      setup(0, 0, 0, 1, 1);
      random_frames(2, 0);
      // zero destination emits nothing; destination beyond coverage
      setup(3, 2, 2, 0, 0);
      random_frames(6, 0);
      setup(3, 3, 2, 5, 5);
      random_frames(9, 0);

      // random frames with random geometry, including clipped edges
      for (int ph = 0; ph < 8; ph++) begin
         sc = $urandom_range(1, 6);
         sw = $urandom_range(1, 24);
         sh = $urandom_range(1, 8);
         setup(sw, sh, sc, (sw + sc - 1) / sc, (sh + sc - 1) / sc);
         random_frames(30, 1);
      end
      // extremes: width 1024 (and an oversized 2047), scale 16 and 16x16 blocks
      setup(2047, 16, 16, 64, 1);
      random_frames(40, 1);
      setup(1024, 1024, 16, 64, 64);
      random_frames(32, 0);
      setup(16, 16, 16, 1, 1);
      random_frames(256, 0);
      // receiver holds off while the sender keeps going, so the block fills up
      setup(16, 4, 2, 8, 2);
      hold_off = 1;
      random_frames(64, 0);
      // sender pauses until all results are in, then back-to-back with no idling
      drain();
      setup(8, 4, 2, 4, 2);
      quiet_rx = 1;
      random_frames(64, 0);
      quiet_rx = 0;
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #(12 * 400000);
      $display("tb: FAIL");
      $finish;
   end
endmodule
